// ===== rtl/srs3_pkg.sv =====
// Shared types, phase codes and the hex decode helper for the S3 line parser.
// No dependencies.
`default_nettype none

package srs3_pkg;

  // Parser phases
  localparam logic [3:0] PH_LEAD  = 4'd0;
  localparam logic [3:0] PH_TYPE  = 4'd1;
  localparam logic [3:0] PH_COUNT = 4'd2;
  localparam logic [3:0] PH_ADDR  = 4'd3;
  localparam logic [3:0] PH_DATA  = 4'd4;
  localparam logic [3:0] PH_CHECK = 4'd5;
  localparam logic [3:0] PH_SKIP  = 4'd6;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SUM     = 2'd1;
  localparam logic [1:0] ST_BADHEX  = 2'd2;
  localparam logic [1:0] ST_BADLEAD = 2'd3;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Characters
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] SUM_INV = 8'hff;

  // Record overhead in the byte count: four address bytes plus checksum
  localparam logic [7:0] REC_OVERHEAD = 8'd5;

  localparam int unsigned TDATA_W = 48;

  typedef struct packed {
    logic [3:0]  phase;
    logic [2:0]  nibble_count;
    logic [3:0]  high_nibble;
    logic [7:0]  count_value;
    logic [7:0]  bytes_left;
    logic [31:0] address_value;
    logic [7:0]  running_sum;
    logic        halted;
  } srs3_state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [31:0] record_address;
    logic [1:0]  status;
  } srs3_res_t;

  // Hex digit decode: bit 4 set when the character is a valid digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/srs3_step.sv =====
// Next-state and result logic for one character of the S3 line parser.
// Depends on srs3_pkg.
`default_nettype none

module srs3_step import srs3_pkg::*; (
  input  wire logic [7:0]  character,
  input  wire srs3_state_t cur,
  output srs3_state_t      nxt,
  output logic             res_valid,
  output srs3_res_t        res
);

  logic [4:0] hx;
  logic       is_hex;
  logic [3:0] nib;
  logic [7:0] byte_val;
  logic [7:0] left_init;
  logic [7:0] left_dec;

  assign hx       = hex_decode(character);
  assign is_hex   = hx[4];
  assign nib      = hx[3:0];
  assign byte_val = {cur.high_nibble, nib};
  assign left_init = (cur.count_value >= REC_OVERHEAD) ?
                     (cur.count_value - REC_OVERHEAD) : 8'd0;
  assign left_dec = cur.bytes_left - 8'd1;

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res.kind           = KIND_DATA;
    res.data_byte      = 8'd0;
    res.record_address = cur.address_value;
    res.status         = ST_OK;

    if (!cur.halted) begin
      case (cur.phase)
        PH_LEAD: begin
          if (character == CH_LF || character == CH_CR) begin
            nxt.phase = PH_LEAD;
          end else if (character != CH_S) begin
            nxt.halted = 1'b1;
            res_valid  = 1'b1;
            res.kind   = KIND_STATUS;
            res.status = ST_BADLEAD;
          end else begin
            nxt.phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (character == CH_LF) begin
            nxt.phase = PH_LEAD;
          end else if (character == CH_3) begin
            nxt.phase        = PH_COUNT;
            nxt.nibble_count = 3'd0;
          end else begin
            nxt.phase = PH_SKIP;
          end
        end
        PH_COUNT, PH_ADDR, PH_DATA, PH_CHECK: begin
          if (!is_hex) begin
            nxt.halted = 1'b1;
            res_valid  = 1'b1;
            res.kind   = KIND_STATUS;
            res.status = ST_BADHEX;
          end else if (cur.phase == PH_ADDR) begin
            nxt.address_value = {cur.address_value[27:0], nib};
            if (cur.nibble_count[0]) begin
              nxt.running_sum = cur.running_sum + byte_val;
            end else begin
              nxt.high_nibble = nib;
            end
            if (cur.nibble_count == 3'd7) begin
              nxt.nibble_count = 3'd0;
              nxt.bytes_left   = left_init;
              nxt.phase        = (left_init != 8'd0) ? PH_DATA : PH_CHECK;
            end else begin
              nxt.nibble_count = cur.nibble_count + 3'd1;
            end
          end else if (!cur.nibble_count[0]) begin
            nxt.high_nibble  = nib;
            nxt.nibble_count = 3'd1;
          end else begin
            nxt.nibble_count = 3'd0;
            if (cur.phase == PH_COUNT) begin
              nxt.count_value   = byte_val;
              nxt.running_sum   = byte_val;
              nxt.address_value = 32'd0;
              nxt.phase         = PH_ADDR;
            end else if (cur.phase == PH_DATA) begin
              nxt.running_sum = cur.running_sum + byte_val;
              nxt.bytes_left  = left_dec;
              if (left_dec == 8'd0) begin
                nxt.phase = PH_CHECK;
              end
              res_valid     = 1'b1;
              res.data_byte = byte_val;
            end else begin
              // checksum digit pair
              nxt.phase = PH_SKIP;
              res_valid = 1'b1;
              res.kind  = KIND_STATUS;
              if (byte_val != (cur.running_sum ^ SUM_INV)) begin
                nxt.halted = 1'b1;
                res.status = ST_SUM;
              end
            end
          end
        end
        default: begin
          // skip to end of line
          if (character == CH_LF) begin
            nxt.phase = PH_LEAD;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srs3_out_buf.sv =====
// Two-entry result buffer between the parser logic and the output channel.
// Depends on srs3_pkg.
`default_nettype none

module srs3_out_buf import srs3_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire srs3_res_t push_data,
  output logic           has_room,
  output logic           out_valid,
  input  wire logic      out_ready,
  output srs3_res_t      out_data
);

  logic [1:0] cnt_r, cnt_nxt;
  srs3_res_t  slot0_r, slot1_r;
  srs3_res_t  slot0_nxt, slot1_nxt;
  logic       pop;
  logic [1:0] wpos;

  assign out_valid = (cnt_r != 2'd0);
  assign has_room  = (cnt_r != 2'd2);
  assign out_data  = slot0_r;
  assign pop       = out_valid && out_ready;
  assign wpos      = cnt_r - {1'b0, pop};
  assign cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, pop};

  // shift on pop, then write the incoming entry at the first free slot
  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (pop) begin
      slot0_nxt = slot1_r;
    end
    if (push) begin
      if (wpos == 2'd0) begin
        slot0_nxt = push_data;
      end else begin
        slot1_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/srecord_s3_line_parser_core.sv =====
// Top level of the S3 record line parser: parser state, step logic, result buffer.
// Depends on srs3_pkg, srs3_step and srs3_out_buf.
//
//  Channel | Ports                      | Dir | Payload
//  --------+----------------------------+-----+--------------------------------------
//  input   | in_tvalid/in_tready/tdata  | in  | tdata[7:0] character
//  result  | out_tvalid/out_tready/...  | out | tuser[0] kind; tdata[7:0] data_byte,
//          |                            |     | [39:8] record_address, [41:40] status
//
// One character per cycle while in_tready is high; each transaction updates
// the parser state in the cycle it is accepted and yields at most one result
// into a two-entry buffer. in_tready drops only when both buffer entries are
// full, so one more character is taken while a result waits on a stalled
// output. Synchronous active-low reset returns to the line-start phase, clears
// the halt flag and empties the buffer. Once halted, characters are still
// consumed but produce nothing until reset.
`default_nettype none

module srecord_s3_line_parser_core import srs3_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,    // [7:0] character
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,   // [7:0] data_byte, [39:8] record_address,
                                               // [41:40] status, rest zero
  output logic                    out_tuser    // [0] kind
);

  srs3_state_t st_r, st_nxt, step_nxt;
  srs3_res_t   step_res, head;
  logic        step_valid;
  logic        accept;
  logic        room;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = room;

  srs3_step u_step (
    .character (in_tdata),
    .cur       (st_r),
    .nxt       (step_nxt),
    .res_valid (step_valid),
    .res       (step_res)
  );

  assign st_nxt = accept ? step_nxt : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_LEAD, nibble_count: 3'd0, high_nibble: 4'd0,
                count_value: 8'd0, bytes_left: 8'd0, address_value: 32'd0,
                running_sum: 8'd0, halted: 1'b0};
    end else begin
      st_r <= st_nxt;
    end
  end

  srs3_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && step_valid),
    .push_data (step_res),
    .has_room  (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (head)
  );

  assign out_tuser = head.kind;
  assign out_tdata = {6'd0, head.status, head.record_address, head.data_byte};

endmodule

`default_nettype wire

// ===== tb/srecord_s3_line_parser_core_tb.sv =====
// Self-checking testbench for srecord_s3_line_parser_core: streams S-record text in and
// checks every data byte and status transaction against a built-in line parser model.
// Depends on srs3_pkg and the RTL top level only.
`timescale 1ns / 100ps

module srecord_s3_line_parser_core_tb import srs3_pkg::*; ();

  localparam int ITEM_TARGET  = 1350;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 40;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
  typedef enum {FAULT_SUM, FAULT_LEAD, FAULT_HEX_COUNT, FAULT_HEX_ADDR,
                FAULT_HEX_DATA, FAULT_HEX_CHECK} fault_t;

  // Parser model plus the queue of records it expects on the result channel.
  class S3LineScoreboard;
    logic [3:0]  ph;
    logic [2:0]  nib_cnt;
    logic [3:0]  hi_nib;
    logic [7:0]  byte_cnt;
    logic [7:0]  data_left;
    logic [31:0] load_addr;
    logic [7:0]  sum;
    logic        stopped;
    srs3_res_t   pending[$];
    int errors, n_chars, n_data, n_status;

    function new();
      ph = PH_LEAD;
      nib_cnt = '0;
      hi_nib = '0;
      byte_cnt = '0;
      data_left = '0;
      load_addr = '0;
      sum = '0;
      stopped = 1'b0;
    endfunction

    // bit 4 flags a legal hex digit, bits 3:0 hold its value
    static function logic [4:0] digit_of(logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= "0" && c <= "9") begin
        v = c - "0";
        return {1'b1, v[3:0]};
      end
      if (c >= "A" && c <= "F") begin
        v = c - "A" + 8'd10;
        return {1'b1, v[3:0]};
      end
      if (c >= "a" && c <= "f") begin
        v = c - "a" + 8'd10;
        return {1'b1, v[3:0]};
      end
      return 5'd0;
    endfunction

    // Advance the model by one accepted character; queue a result if one is due.
    function void note_char(logic [7:0] c);
      logic [4:0] d;
      logic [7:0] b;
      srs3_res_t  r;
      bit         emit;
      emit = 1'b0;
      r = '0;
      n_chars++;
      if (stopped) return;
      case (ph)
        PH_LEAD: begin
          if (c == CH_S) begin
            ph = PH_TYPE;
          end else if (c != CH_LF && c != CH_CR) begin
            stopped = 1'b1;
            emit = 1'b1;
            r.kind = KIND_STATUS;
            r.status = ST_BADLEAD;
          end
        end
        PH_TYPE: begin
          if (c == CH_LF) begin
            ph = PH_LEAD;
          end else if (c == CH_3) begin
            ph = PH_COUNT;
            nib_cnt = '0;
          end else begin
            ph = PH_SKIP;
          end
        end
        PH_COUNT, PH_ADDR, PH_DATA, PH_CHECK: begin
          d = digit_of(c);
          if (!d[4]) begin
            stopped = 1'b1;
            emit = 1'b1;
            r.kind = KIND_STATUS;
            r.status = ST_BADHEX;
          end else if (ph == PH_ADDR) begin
            load_addr = {load_addr[27:0], d[3:0]};
            if (nib_cnt[0]) sum = sum + {hi_nib, d[3:0]};
            else hi_nib = d[3:0];
            if (nib_cnt == 3'd7) begin
              nib_cnt = '0;
              data_left = (byte_cnt >= REC_OVERHEAD) ? byte_cnt - REC_OVERHEAD : 8'd0;
              ph = (data_left != 0) ? PH_DATA : PH_CHECK;
            end else begin
              nib_cnt = nib_cnt + 3'd1;
            end
          end else if (!nib_cnt[0]) begin
            hi_nib = d[3:0];
            nib_cnt = 3'd1;
          end else begin
            nib_cnt = '0;
            b = {hi_nib, d[3:0]};
            if (ph == PH_COUNT) begin
              byte_cnt = b;
              sum = b;
              load_addr = '0;
              ph = PH_ADDR;
            end else if (ph == PH_DATA) begin
              sum = sum + b;
              data_left = data_left - 8'd1;
              if (data_left == 0) ph = PH_CHECK;
              emit = 1'b1;
              r.kind = KIND_DATA;
              r.data_byte = b;
              r.status = ST_OK;
            end else begin
              ph = PH_SKIP;
              emit = 1'b1;
              r.kind = KIND_STATUS;
              if (b != (sum ^ SUM_INV)) begin
                stopped = 1'b1;
                r.status = ST_SUM;
              end else begin
                r.status = ST_OK;
              end
            end
          end
        end
        default: begin
          if (c == CH_LF) ph = PH_LEAD;
        end
      endcase
      if (emit) begin
        r.record_address = load_addr;
        pending.push_back(r);
      end
    endfunction

    function void mismatch(string field, logic [31:0] want, logic [31:0] got);
      if (errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    endfunction

    // Compare one result transaction against the oldest expectation.
    function void check_result(logic kind, logic [TDATA_W-1:0] tdata);
      srs3_res_t want;
      if (pending.size() == 0) begin
        mismatch("unexpected result, tdata[31:0]", 32'h0, tdata[31:0]);
        return;
      end
      want = pending.pop_front();
      if (want.kind == KIND_DATA) n_data++;
      else n_status++;
      if (kind !== want.kind) mismatch("kind", 32'(want.kind), 32'(kind));
      if (tdata[7:0] !== want.data_byte)
        mismatch("data_byte", 32'(want.data_byte), 32'(tdata[7:0]));
      if (tdata[39:8] !== want.record_address)
        mismatch("record_address", want.record_address, tdata[39:8]);
      if (tdata[41:40] !== want.status)
        mismatch("status", 32'(want.status), 32'(tdata[41:40]));
      if (tdata[TDATA_W-1:42] !== '0)
        mismatch("tdata pad", 32'h0, 32'(tdata[TDATA_W-1:42]));
    endfunction
  endclass

  // DUT signals; every input starts at a known value
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = 8'h00;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;
  logic                out_tuser;

  S3LineScoreboard sb;
  logic [7:0] line_buf[$];     // characters of the record being assembled
  int  cycle_count = 0;
  int  burst_left = 0;
  int  n_records = 0;
  int  n_other = 0;
  int  stall_mode = 0;
  fault_t fault;

  srecord_s3_line_parser_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, sb.pending.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check each completed transaction, then pick next cycle's tready.
  // The stall style is redrawn periodically: always ready, coin flip,
  // a periodic stall pattern, or long stalls with rare ready pulses.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
    if (cycle_count % 256 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) == 1);
      2:       out_tready <= (cycle_count % 7) >= 3;
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Hex digit as text, letters in random case so both alphabets get exercised.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    return ($urandom_range(0, 1) ? "A" : "a") + n - 8'd10;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
    return c;
  endfunction

  // Drive one character; the sender runs in bursts with random gaps between them.
  // Acceptance is judged on the values present at the edge, then the model steps.
  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 48);
      repeat (gap) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    sb.note_char(c);
  endtask

  task automatic push_hex(input logic [7:0] b);
    line_buf.push_back(hex_char(b[7:4]));
    line_buf.push_back(hex_char(b[3:0]));
  endtask

  // Assemble a full S3 line (no line ending) into line_buf. A nonzero
  // sum_flip corrupts the checksum.
  task automatic build_s3(input logic [7:0] count, input logic [31:0] addr,
                          input fill_t fill, input logic [7:0] sum_flip);
    logic [7:0] sum;
    logic [7:0] b;
    int         nd;
    line_buf.delete();
    line_buf.push_back(CH_S);
    line_buf.push_back(CH_3);
    push_hex(count);
    sum = count;
    for (int i = 3; i >= 0; i--) begin
      push_hex(addr[i*8 +: 8]);
      sum = sum + addr[i*8 +: 8];
    end
    nd = (count >= REC_OVERHEAD) ? int'(count - REC_OVERHEAD) : 0;
    for (int i = 0; i < nd; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hff;
        default:   b = 8'($urandom_range(0, 255));
      endcase
      push_hex(b);
      sum = sum + b;
    end
    push_hex((sum ^ SUM_INV) ^ sum_flip);
  endtask

  task automatic send_line_buf();
    foreach (line_buf[i]) send_char(line_buf[i]);
  endtask

  // End of a line: optional junk after the checksum, then LF or CR LF.
  task automatic close_line(input bit with_trail);
    if (with_trail) repeat ($urandom_range(1, 4)) send_char(junk_char());
    if ($urandom_range(0, 1)) send_char(CH_CR);
    send_char(CH_LF);
  endtask

  task automatic send_s3(input logic [7:0] count, input logic [31:0] addr,
                         input fill_t fill, input bit with_trail);
    build_s3(count, addr, fill, 8'h00);
    send_line_buf();
    close_line(with_trail);
    n_records++;
  endtask

  // A record of another type: skipped by the parser up to the newline.
  task automatic send_other_line(input logic [7:0] rec_kind);
    send_char(CH_S);
    send_char(rec_kind);
    repeat ($urandom_range(0, 30)) send_char(junk_char());
    send_char(CH_LF);
    n_other++;
  endtask

  // Last part of the run: one halting fault, then noise that must produce nothing.
  task automatic send_fault();
    logic [7:0] c;
    logic [7:0] count;
    int         nd;
    int         pos;
    fault = fault_t'($urandom_range(0, 5));
    count = (fault == FAULT_HEX_DATA) ? 8'($urandom_range(6, 12)) :
                                        8'($urandom_range(0, 12));
    nd = (count >= REC_OVERHEAD) ? int'(count - REC_OVERHEAD) : 0;
    case (fault)
      FAULT_LEAD: begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_S || c == CH_LF || c == CH_CR);
        send_char(c);
      end
      FAULT_SUM: begin
        build_s3(count, $urandom, FILL_RANDOM, 8'($urandom_range(1, 255)));
        send_line_buf();
        close_line(1'b0);
      end
      default: begin
        build_s3(count, $urandom, FILL_RANDOM, 8'h00);
        case (fault)
          FAULT_HEX_COUNT: pos = $urandom_range(2, 3);
          FAULT_HEX_ADDR:  pos = $urandom_range(4, 11);
          FAULT_HEX_DATA:  pos = $urandom_range(12, 11 + 2 * nd);
          default:         pos = $urandom_range(12 + 2 * nd, 13 + 2 * nd);
        endcase
        while (line_buf.size() > pos) void'(line_buf.pop_back());
        // line endings count as bad digits inside a record too
        case ($urandom_range(0, 3))
          0:       c = CH_LF;
          1:       c = CH_CR;
          default: begin
            do c = 8'($urandom_range(0, 255));
            while (S3LineScoreboard::digit_of(c) != 0);
          end
        endcase
        line_buf.push_back(c);
        send_line_buf();
      end
    endcase
    repeat (24) send_char(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int          pick;
    logic [7:0]  count;
    logic [7:0]  rec_kind;
    logic [31:0] addr;
    fill_t       fill;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: blank lines, bare lead, other record types, field extremes,
    // short counts, all-zero and all-one data, trailing junk, maximum count.
    send_char(CH_LF);
    send_char(CH_CR);
    send_char(CH_S);
    send_char(CH_LF);
    send_other_line("1");
    send_other_line(8'hff);
    send_other_line(8'h00);
    send_s3(8'h05, 32'h0000_0000, FILL_ZERO, 1'b0);
    send_s3(8'h00, 32'hffff_ffff, FILL_RANDOM, 1'b0);
    send_s3(8'h04, 32'h1234_5678, FILL_RANDOM, 1'b0);
    send_s3(8'h07, 32'h89ab_cdef, FILL_ONES, 1'b1);
    send_s3(8'h06, $urandom, FILL_ZERO, 1'b0);
    send_s3(8'hff, $urandom, FILL_RANDOM, 1'b0);
    send_char(CH_CR);
    send_char(CH_LF);

    // Random: mostly well-formed S3 lines with random content, the rest other
    // record types, empty lines and bare leads. Anything halting is kept for the end.
    while (sb.n_chars < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 59))
          0, 1, 2: count = 8'($urandom_range(0, 4));
          3:       count = 8'hff;
          4:       count = 8'($urandom_range(21, 60));
          default: count = 8'($urandom_range(5, 20));
        endcase
        case ($urandom_range(0, 9))
          0:       addr = 32'h0000_0000;
          1:       addr = 32'hffff_ffff;
          default: addr = $urandom;
        endcase
        case ($urandom_range(0, 9))
          0:       fill = FILL_ZERO;
          1:       fill = FILL_ONES;
          default: fill = FILL_RANDOM;
        endcase
        send_s3(count, addr, fill, $urandom_range(0, 4) == 0);
      end else if (pick < 85) begin
        do rec_kind = 8'($urandom_range(0, 255));
        while (rec_kind == CH_3 || rec_kind == CH_LF);
        send_other_line(rec_kind);
      end else if (pick < 95) begin
        send_char($urandom_range(0, 1) ? CH_LF : CH_CR);
      end else begin
        send_char(CH_S);
        send_char(CH_LF);
      end
    end

    send_fault();
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    // a result still waiting here was never expected
    if (out_tvalid !== 1'b0) sb.mismatch("leftover out_tvalid", 32'h0, 32'(out_tvalid));

    $display("Streamed %0d characters: %0d S3 records, %0d other-type lines, fault %s at the end",
             sb.n_chars, n_records, n_other, fault.name());
    $display("Checked %0d data byte and %0d status transactions, %0d mismatches",
             sb.n_data, sb.n_status, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
